[sv/ied_pkg.sv]
// Shared types and constants for the input episode detector.
// Used by every module of the block; it depends on nothing else.
package ied_pkg;

	// Field widths.
	localparam int COORD_W = 16;
	localparam int ID_W    = 32;
	localparam int MAG_W   = COORD_W;
	localparam int SEQ_W   = 32;
	localparam int TIME_W  = 64;
	localparam int THR_W   = 16;
	localparam int SETTLE_W = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	// Widths of the id and magnitude as they leave the block.
	localparam int EVT_ID_W  = 32;
	localparam int EVT_MAG_W = 16;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH = 2;

	// Event kinds.
	localparam logic [1:0] KIND_STARTED  = 2'd0;
	localparam logic [1:0] KIND_PEAK     = 2'd1;
	localparam logic [1:0] KIND_REVERSED = 2'd2;
	localparam logic [1:0] KIND_ENDED    = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_THR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME = 2'd2;

	// Configuration reset values.
	localparam logic [THR_W-1:0]    ACTIVE_THR_RST  = 16'd8192;
	localparam logic [THR_W-1:0]    RELEASE_THR_RST = 16'd4096;
	localparam logic [SETTLE_W-1:0] SETTLE_RST      = 32'd50000000;

	// One input sample.
	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [SEQ_W-1:0]          seq_number;
		logic [TIME_W-1:0]         time_ns;
	} sample_t;

	// One result event.
	typedef struct packed {
		logic [1:0]           event_kind;
		logic [EVT_ID_W-1:0]  episode_number;
		logic [SEQ_W-1:0]     event_seq;
		logic [TIME_W-1:0]    event_time_ns;
		logic [EVT_MAG_W-1:0] event_magnitude;
		logic                 last_of_run;
	} event_t;

	// A measured sample as it travels from the front to the back.
	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic [MAG_W-1:0]          mag;
		logic [SEQ_W-1:0]          seq_number;
		logic [TIME_W-1:0]         time_ns;
	} meas_t;

	// Configuration register set.
	typedef struct packed {
		logic [THR_W-1:0]    active_thr;
		logic [THR_W-1:0]    release_thr;
		logic [SETTLE_W-1:0] settle_time;
	} cfg_t;

endpackage

[sv/input_episode_detector.sv]
// Input episode detector: one two-axis sample in, zero to three events out.
// A sample passes through the front in steps: capture, squaring, sum, and a
// square root that finds one magnitude bit per cycle; the front takes no new
// sample until it has handed the last one to the queue. A two-entry queue lets the
// front keep measuring while the back delivers events, one per cycle when the
// consumer is ready. Configuration registers are written with cfg_we, and a
// write to an unused index is ignored.
// Top level; depends on ied_pkg, ied_front, ied_queue and ied_back.
module input_episode_detector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ied_pkg::sample_t                   in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ied_pkg::event_t                    out_data,
	input  logic                               cfg_we,
	input  logic [ied_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ied_pkg::CFG_W-1:0]          cfg_wdata
);
	import ied_pkg::*;

	cfg_t  cfg_q;
	logic  push, q_full, q_not_empty, pop;
	meas_t push_data, head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_thr  <= ACTIVE_THR_RST;
			cfg_q.release_thr <= RELEASE_THR_RST;
			cfg_q.settle_time <= SETTLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_THR:  cfg_q.active_thr  <= cfg_wdata[THR_W-1:0];
				REG_RELEASE_THR: cfg_q.release_thr <= cfg_wdata[THR_W-1:0];
				REG_SETTLE_TIME: cfg_q.settle_time <= cfg_wdata[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	ied_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	ied_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	ied_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

[sv/ied_front.sv]
// Front part of the episode detector: takes a sample and measures its magnitude.
// The magnitude is an exact floor square root found one result bit per cycle.
// Depends on ied_pkg.
module ied_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ied_pkg::sample_t in_data,
	output logic            push,
	output ied_pkg::meas_t  push_data,
	input  logic            q_full
);
	import ied_pkg::*;

	localparam int RAD_W = 2 * COORD_W;
	localparam int REM_W = COORD_W + 3;
	localparam int CNT_W = $clog2(COORD_W);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_PUSH = 3'd4;

	logic [2:0]         state_q;
	sample_t            smp_q;
	logic [COORD_W-1:0] ax_q, ay_q;
	logic [RAD_W-1:0]   sqx_q, sqy_q, rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [COORD_W-1:0] root_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [REM_W-1:0]   rem_shift, trial;
	logic               fits;

	// One step of the digit-by-digit square root.
	assign rem_shift = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign fits      = rem_shift >= trial;

	assign in_ready = (state_q == ST_IDLE);
	assign push     = (state_q == ST_PUSH) && !q_full;

	always_comb begin
		push_data.pos_x      = smp_q.pos_x;
		push_data.mag        = root_q;
		push_data.seq_number = smp_q.seq_number;
		push_data.time_ns    = smp_q.time_ns;
	end

	// Control sequence: capture, square, sum, iterate the root, hand off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SQ;
				end
				ST_SQ:   state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= ST_ROOT;
					cnt_q   <= '0;
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(COORD_W - 1)) state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!q_full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					smp_q <= in_data;
					ax_q  <= in_data.pos_x[COORD_W-1] ? (~in_data.pos_x + 1'b1)
						: in_data.pos_x;
					ay_q  <= in_data.pos_y[COORD_W-1] ? (~in_data.pos_y + 1'b1)
						: in_data.pos_y;
				end
			end
			ST_SQ: begin
				sqx_q <= RAD_W'(ax_q) * RAD_W'(ax_q);
				sqy_q <= RAD_W'(ay_q) * RAD_W'(ay_q);
			end
			ST_SUM: begin
				rad_q  <= sqx_q + sqy_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				rad_q <= {rad_q[RAD_W-3:0], 2'b00};
				if (fits) begin
					rem_q  <= rem_shift - trial;
					root_q <= {root_q[COORD_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_shift;
					root_q <= {root_q[COORD_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

endmodule

[sv/ied_queue.sv]
// Short queue between the front and the back of the episode detector.
// Holds measured samples in order; depends on ied_pkg.
module ied_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ied_pkg::meas_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output ied_pkg::meas_t head
);
	import ied_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	meas_t            mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

[sv/ied_back.sv]
// Back part of the episode detector: episode state and event generation.
// Takes measured samples from the queue and emits up to three events each.
// Depends on ied_pkg.
module ied_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ied_pkg::cfg_t   cfg,
	input  logic            q_not_empty,
	input  ied_pkg::meas_t  head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output ied_pkg::event_t out_data
);
	import ied_pkg::*;

	// Episode state.
	logic                      active_q;
	logic [ID_W-1:0]           cur_ep_q, next_ep_q;
	logic [MAG_W-1:0]          peak_q;
	logic signed [COORD_W-1:0] lsx_q;
	logic [TIME_W-1:0]         bst_q;

	// Pending event run.
	logic              busy_q;
	logic [1:0]        kinds_q [3];
	logic [1:0]        n_q, idx_q;
	logic [ID_W-1:0]   ev_ep_q;
	logic [SEQ_W-1:0]  ev_seq_q;
	logic [TIME_W-1:0] ev_time_q;
	logic [MAG_W-1:0]  ev_mag_q;

	// Decision for the sample at the head of the queue.
	logic                      nx_active;
	logic [ID_W-1:0]           nx_cur, nx_next, nx_ep;
	logic [MAG_W-1:0]          nx_peak;
	logic signed [COORD_W-1:0] nx_lsx;
	logic [TIME_W-1:0]         nx_bst, bst_run, elapsed;
	logic [1:0]                nk [3];
	logic [1:0]                nn;
	logic [COORD_W-1:0]        ax, alsx;
	logic                      x_strong, last_strong, opposite;

	assign ax   = head.pos_x[COORD_W-1] ? (~head.pos_x + 1'b1) : head.pos_x;
	assign alsx = lsx_q[COORD_W-1] ? (~lsx_q + 1'b1) : lsx_q;
	assign x_strong    = ax >= cfg.active_thr;
	assign last_strong = alsx >= cfg.active_thr;
	assign opposite    = (head.pos_x[COORD_W-1] && !lsx_q[COORD_W-1] && lsx_q != '0)
		|| (!head.pos_x[COORD_W-1] && head.pos_x != '0 && lsx_q[COORD_W-1]);
	assign bst_run = (bst_q == '0) ? head.time_ns : bst_q;
	assign elapsed = head.time_ns - bst_run;

	assign pop = q_not_empty && !busy_q;

	// Work out the events and the next state for one sample.
	always_comb begin
		nx_active = active_q;
		nx_cur    = cur_ep_q;
		nx_next   = next_ep_q;
		nx_peak   = peak_q;
		nx_lsx    = lsx_q;
		nx_bst    = bst_q;
		nx_ep     = cur_ep_q;
		nk[0]     = KIND_STARTED;
		nk[1]     = KIND_PEAK;
		nk[2]     = KIND_PEAK;
		nn        = 2'd0;
		if (!active_q) begin
			if (head.mag >= cfg.active_thr) begin
				nx_active = 1'b1;
				nx_cur    = next_ep_q;
				nx_next   = next_ep_q + 1'b1;
				nx_ep     = next_ep_q;
				nx_peak   = head.mag;
				nx_lsx    = head.pos_x;
				nx_bst    = '0;
				nk[0]     = KIND_STARTED;
				nk[1]     = KIND_PEAK;
				nn        = 2'd2;
			end
		end else begin
			if (head.mag > peak_q) begin
				nx_peak = head.mag;
				nk[nn]  = KIND_PEAK;
				nn      = nn + 2'd1;
			end
			if (x_strong && last_strong && opposite) begin
				nk[nn] = KIND_REVERSED;
				nn     = nn + 2'd1;
			end
			if (x_strong) nx_lsx = head.pos_x;
			if (head.mag <= cfg.release_thr) begin
				nx_bst = bst_run;
				if (elapsed >= TIME_W'(cfg.settle_time)) begin
					nk[nn]    = KIND_ENDED;
					nn        = nn + 2'd1;
					nx_active = 1'b0;
					nx_cur    = '0;
					nx_bst    = '0;
				end
			end else begin
				nx_bst = '0;
			end
		end
	end

	// Output side: present the stored run one event at a time.
	assign out_valid = busy_q;
	always_comb begin
		out_data.event_kind      = kinds_q[idx_q];
		out_data.episode_number  = EVT_ID_W'(ev_ep_q);
		out_data.event_seq       = ev_seq_q;
		out_data.event_time_ns   = ev_time_q;
		out_data.event_magnitude = EVT_MAG_W'(ev_mag_q);
		out_data.last_of_run     = (idx_q == n_q - 2'd1);
	end

	// State and run control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			cur_ep_q  <= '0;
			next_ep_q <= ID_W'(1);
			peak_q    <= '0;
			lsx_q     <= '0;
			bst_q     <= '0;
			busy_q    <= 1'b0;
			n_q       <= 2'd0;
			idx_q     <= 2'd0;
		end else begin
			if (pop) begin
				active_q  <= nx_active;
				cur_ep_q  <= nx_cur;
				next_ep_q <= nx_next;
				peak_q    <= nx_peak;
				lsx_q     <= nx_lsx;
				bst_q     <= nx_bst;
				busy_q    <= (nn != 2'd0);
				n_q       <= nn;
				idx_q     <= 2'd0;
			end else if (busy_q && out_ready) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == n_q - 2'd1) busy_q <= 1'b0;
			end
		end
	end

	// Run payload, captured with the sample.
	always_ff @(posedge clk) begin
		if (pop) begin
			kinds_q[0] <= nk[0];
			kinds_q[1] <= nk[1];
			kinds_q[2] <= nk[2];
			ev_ep_q    <= nx_ep;
			ev_seq_q   <= head.seq_number;
			ev_time_q  <= head.time_ns;
			ev_mag_q   <= head.mag;
		end
	end

endmodule
